// ----- rtl/calcron_pkg.sv -----
package calcron_pkg;

  // Field widths of the calendar clock
  localparam int unsigned SecondW   = 6;
  localparam int unsigned MinuteW   = 6;
  localparam int unsigned HourW     = 5;
  localparam int unsigned WeekdayW  = 3;
  localparam int unsigned MonthDayW = 5;
  localparam int unsigned YearDayW  = 9;
  localparam int unsigned MonthW    = 4;
  localparam int unsigned YearW     = 16;
  localparam int unsigned EpochW    = 32;

  // Configuration port
  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 61;

  // First year for which the clock counts as set
  localparam logic [YearW-1:0] YearValidMin = 16'd2018;

  typedef enum logic {
    CmdTick = 1'b0,
    CmdLoad = 1'b1
  } cmd_e;

  typedef enum logic [CfgIndexW-1:0] {
    CfgSecondMask   = 3'd0,
    CfgMinuteMask   = 3'd1,
    CfgHourMask     = 3'd2,
    CfgMonthDayMask = 3'd3,
    CfgMonthMask    = 3'd4,
    CfgWeekdayMask  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [SecondW-1:0]   second;
    logic [MinuteW-1:0]   minute;
    logic [HourW-1:0]     hour;
    logic [WeekdayW-1:0]  weekday;
    logic [MonthDayW-1:0] month_day;
    logic [YearDayW-1:0]  year_day;
    logic [MonthW-1:0]    month;
    logic [YearW-1:0]     year;
    logic [EpochW-1:0]    epoch;
  } clock_t;

  typedef struct packed {
    logic fire;
    logic valid_res;
    logic fields_in_range;
  } status_t;

  // Days in a month of a common year; an unknown month counts as 31 days
  function automatic logic [MonthDayW-1:0] month_len(input logic [MonthW-1:0] month);
    logic [MonthDayW-1:0] len;
    unique case (month)
      4'd2:                      len = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ----- rtl/calendar_clock_with_cron_match_core.sv -----
// Calendar clock with cron-style alarm match. Each request either ticks the
// clock by one second (cmd 0) or loads every clock field (cmd 1), and gives
// one result with the clock after the request, a valid flag (year 2018 or
// later), a range check and a fire bit from six cron masks written through
// the configuration port (index 0 seconds to 5 weekdays, other indexes are
// ignored, masks reset to zero). A request waits in the input register and its
// result is then registered in the result stage; the block accepts one
// request per cycle as long as results are taken, and a result held by the
// output side stalls only the input register behind it. The configuration
// port is always ready; write it only while no request is in flight.
module calendar_clock_with_cron_match_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration writes
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [calcron_pkg::CfgIndexW-1:0]    cfg_index_i,
  input  logic [calcron_pkg::CfgDataW-1:0]     cfg_data_i,
  // requests
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 cmd_i,
  input  logic [calcron_pkg::SecondW-1:0]      load_second_i,
  input  logic [calcron_pkg::MinuteW-1:0]      load_minute_i,
  input  logic [calcron_pkg::HourW-1:0]        load_hour_i,
  input  logic [calcron_pkg::WeekdayW-1:0]     load_weekday_i,
  input  logic [calcron_pkg::MonthDayW-1:0]    load_month_day_i,
  input  logic [calcron_pkg::YearDayW-1:0]     load_year_day_i,
  input  logic [calcron_pkg::MonthW-1:0]       load_month_i,
  input  logic [calcron_pkg::YearW-1:0]        load_year_i,
  input  logic [calcron_pkg::EpochW-1:0]       load_epoch_i,
  // results
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 fire_o,
  output logic                                 valid_res_o,
  output logic                                 fields_in_range_o,
  output logic [calcron_pkg::SecondW-1:0]      cur_second_o,
  output logic [calcron_pkg::MinuteW-1:0]      cur_minute_o,
  output logic [calcron_pkg::HourW-1:0]        cur_hour_o,
  output logic [calcron_pkg::WeekdayW-1:0]     cur_weekday_o,
  output logic [calcron_pkg::MonthDayW-1:0]    cur_month_day_o,
  output logic [calcron_pkg::YearDayW-1:0]     cur_year_day_o,
  output logic [calcron_pkg::MonthW-1:0]       cur_month_o,
  output logic [calcron_pkg::YearW-1:0]        cur_year_o,
  output logic [calcron_pkg::EpochW-1:0]       cur_epoch_o
);

  logic                  s1_valid_q;
  calcron_pkg::cmd_e     s1_cmd_q;
  calcron_pkg::clock_t   s1_load_q;
  calcron_pkg::clock_t   load_in;
  calcron_pkg::clock_t   clk_q;
  calcron_pkg::clock_t   clk_d;
  calcron_pkg::status_t  status_d;
  calcron_pkg::status_t  status_q;
  logic                  out_valid_q;
  logic                  out_free;
  logic                  s1_adv;
  logic                  in_acc;

  // Handshake: the result stage frees when empty or being taken
  assign out_free    = !out_valid_q || out_ready_i;
  assign s1_adv      = s1_valid_q && out_free;
  assign in_ready_o  = !s1_valid_q || out_free;
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  assign load_in.second    = load_second_i;
  assign load_in.minute    = load_minute_i;
  assign load_in.hour      = load_hour_i;
  assign load_in.weekday   = load_weekday_i;
  assign load_in.month_day = load_month_day_i;
  assign load_in.year_day  = load_year_day_i;
  assign load_in.month     = load_month_i;
  assign load_in.year      = load_year_i;
  assign load_in.epoch     = load_epoch_i;

  // Input register: hold the request until the result stage takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_cmd_q  <= calcron_pkg::cmd_e'(cmd_i);
      s1_load_q <= load_in;
    end
  end

  calcron_advance u_advance (
    .cmd_load_i (s1_cmd_q == calcron_pkg::CmdLoad),
    .cur_i      (clk_q),
    .load_i     (s1_load_q),
    .nxt_o      (clk_d)
  );

  calcron_match u_match (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .clk_val_i   (clk_d),
    .status_o    (status_d)
  );

  // Clock state doubles as the result payload: it only moves when the
  // result stage is free, so it holds while a result waits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        clk_q <= clk_d;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      status_q <= status_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign fire_o            = status_q.fire;
  assign valid_res_o       = status_q.valid_res;
  assign fields_in_range_o = status_q.fields_in_range;
  assign cur_second_o      = clk_q.second;
  assign cur_minute_o      = clk_q.minute;
  assign cur_hour_o        = clk_q.hour;
  assign cur_weekday_o     = clk_q.weekday;
  assign cur_month_day_o   = clk_q.month_day;
  assign cur_year_day_o    = clk_q.year_day;
  assign cur_month_o       = clk_q.month;
  assign cur_year_o        = clk_q.year;
  assign cur_epoch_o       = clk_q.epoch;

`ifndef ASSERT_OFF
  a_fire_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!fire_o || valid_res_o))
    else $error("fire without a valid clock");

  a_valid_matches_year: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (valid_res_o == (cur_year_o >= calcron_pkg::YearValidMin)))
    else $error("valid flag disagrees with year");

  a_tick_epoch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_cmd_q == calcron_pkg::CmdTick) |=>
      (clk_q.epoch == $past(clk_q.epoch) + 32'd1))
    else $error("tick did not advance epoch");

  a_load_takes_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_cmd_q == calcron_pkg::CmdLoad) |=> (clk_q == $past(s1_load_q)))
    else $error("load did not set the clock");

  a_clock_holds_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_adv |=> $stable(clk_q))
    else $error("clock moved without a request");
`endif

endmodule

// ----- rtl/calcron_advance.sv -----
module calcron_advance (
  input  logic                  cmd_load_i,
  input  calcron_pkg::clock_t   cur_i,
  input  calcron_pkg::clock_t   load_i,
  output calcron_pkg::clock_t   nxt_o
);

  logic                                    leap;
  logic [calcron_pkg::MonthDayW-1:0]       dim;
  logic [calcron_pkg::YearDayW-1:0]        last_yday;
  logic                                    sec_carry;
  logic                                    min_carry;
  logic                                    hour_carry;
  logic                                    mday_carry;
  calcron_pkg::clock_t                     tick_clk;

  // Work out the carries from the clock before the tick
  assign leap       = (cur_i.year[1:0] == 2'b00);
  assign sec_carry  = (cur_i.second >= 6'd59);
  assign min_carry  = (cur_i.minute >= 6'd59);
  assign hour_carry = (cur_i.hour >= 5'd23);
  assign last_yday  = leap ? 9'd366 : 9'd365;

  always_comb begin
    dim = calcron_pkg::month_len(cur_i.month);
    if (cur_i.month == 4'd2 && leap) begin
      dim = 5'd29;
    end
  end

  assign mday_carry = (cur_i.month_day >= dim);

  // Advance by one second, carrying up through the calendar
  always_comb begin
    tick_clk       = cur_i;
    tick_clk.epoch = cur_i.epoch + 32'd1;
    tick_clk.second = sec_carry ? 6'd0 : cur_i.second + 6'd1;
    if (sec_carry) begin
      tick_clk.minute = min_carry ? 6'd0 : cur_i.minute + 6'd1;
      if (min_carry) begin
        tick_clk.hour = hour_carry ? 5'd0 : cur_i.hour + 5'd1;
        if (hour_carry) begin
          tick_clk.weekday   = (cur_i.weekday >= 3'd7) ? 3'd1 : cur_i.weekday + 3'd1;
          tick_clk.month_day = mday_carry ? 5'd1 : cur_i.month_day + 5'd1;
          if (mday_carry) begin
            tick_clk.month = (cur_i.month >= 4'd12) ? 4'd1 : cur_i.month + 4'd1;
          end
          if (cur_i.year_day >= last_yday) begin
            tick_clk.year_day = 9'd1;
            tick_clk.year     = cur_i.year + 16'd1;
          end else begin
            tick_clk.year_day = cur_i.year_day + 9'd1;
          end
        end
      end
    end
  end

  // Take the load fields or the ticked clock
  assign nxt_o = cmd_load_i ? load_i : tick_clk;

endmodule

// ----- rtl/calcron_match.sv -----
module calcron_match (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [calcron_pkg::CfgIndexW-1:0]    cfg_index_i,
  input  logic [calcron_pkg::CfgDataW-1:0]     cfg_data_i,
  input  calcron_pkg::clock_t                  clk_val_i,
  output calcron_pkg::status_t                 status_o
);

  logic [60:0] second_mask_q;
  logic [59:0] minute_mask_q;
  logic [23:0] hour_mask_q;
  logic [31:0] month_day_mask_q;
  logic [12:0] month_mask_q;
  logic [7:0]  weekday_mask_q;

  logic [63:0] second_vec;
  logic [63:0] minute_vec;
  logic [31:0] hour_vec;
  logic [15:0] month_vec;
  logic        all_sel;
  logic        valid_res;

  // Hold the cron masks; writes to unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      second_mask_q    <= '0;
      minute_mask_q    <= '0;
      hour_mask_q      <= '0;
      month_day_mask_q <= '0;
      month_mask_q     <= '0;
      weekday_mask_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        calcron_pkg::CfgSecondMask:   second_mask_q    <= cfg_data_i[60:0];
        calcron_pkg::CfgMinuteMask:   minute_mask_q    <= cfg_data_i[59:0];
        calcron_pkg::CfgHourMask:     hour_mask_q      <= cfg_data_i[23:0];
        calcron_pkg::CfgMonthDayMask: month_day_mask_q <= cfg_data_i[31:0];
        calcron_pkg::CfgMonthMask:    month_mask_q     <= cfg_data_i[12:0];
        calcron_pkg::CfgWeekdayMask:  weekday_mask_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Pad the narrower masks so that values above their width read as not selected
  assign second_vec = {3'b000, second_mask_q};
  assign minute_vec = {4'b0000, minute_mask_q};
  assign hour_vec   = {8'h00, hour_mask_q};
  assign month_vec  = {3'b000, month_mask_q};

  assign all_sel = second_vec[clk_val_i.second] & minute_vec[clk_val_i.minute] &
                   hour_vec[clk_val_i.hour] & month_day_mask_q[clk_val_i.month_day] &
                   month_vec[clk_val_i.month] & weekday_mask_q[clk_val_i.weekday];

  assign valid_res = (clk_val_i.year >= calcron_pkg::YearValidMin);

  assign status_o.valid_res = valid_res;
  assign status_o.fire      = valid_res & all_sel;

  // Check every calendar field but the year against its legal range; the month day is only checked for zero
  assign status_o.fields_in_range =
      (clk_val_i.second < 6'd61) && (clk_val_i.minute < 6'd60) &&
      (clk_val_i.hour < 5'd24) && (clk_val_i.weekday != 3'd0) &&
      (clk_val_i.month_day != 5'd0) &&
      (clk_val_i.year_day != 9'd0) && (clk_val_i.year_day <= 9'd366) &&
      (clk_val_i.month != 4'd0) && (clk_val_i.month <= 4'd12);

endmodule
